// File: hw/rtl/afrlp_pkg.sv
// ----------------------------------------------------------------------------
// afrlp_pkg
// Shared types and constants for the audio format rate list parser.
// ----------------------------------------------------------------------------
package afrlp_pkg;

  // Default for the largest rate count the block handles.
  localparam int MaxRatesDefault = 16;

  // Descriptor layout.
  localparam logic [7:0] DescType    = 8'h24;
  localparam logic [7:0] DescSubtype = 8'h02;
  localparam logic [5:0] MinLen      = 6'd11;
  localparam logic [5:0] ListStart   = 6'd8;
  localparam logic [5:0] PosCountB   = 6'd7;
  localparam logic [5:0] PosTypeB    = 6'd1;
  localparam logic [5:0] PosSubtypeB = 6'd2;
  localparam logic [5:0] PosMax      = 6'd63;

  // Status codes.
  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StShort     = 3'd1;
  localparam logic [2:0] StBadType   = 3'd2;
  localparam logic [2:0] StBadCount  = 3'd3;
  localparam logic [2:0] StTruncated = 3'd4;

  // Byte phase within one three-byte rate.
  localparam logic [1:0] PhLow = 2'd0;
  localparam logic [1:0] PhMid = 2'd1;
  localparam logic [1:0] PhHigh = 2'd2;

  // Result queue depth.
  localparam int QueueDepth = 4;

  // One result item.
  typedef struct packed {
    logic        is_status;
    logic [23:0] rate_value;
    logic [3:0]  rate_index;
    logic [2:0]  status_code;
    logic [4:0]  rate_count;
    logic        last_result;
  } afrlp_item_t;

  // Results produced by one accepted byte: up to two, in order.
  typedef struct packed {
    logic [1:0]  num;
    afrlp_item_t item0;
    afrlp_item_t item1;
  } afrlp_push_t;

endpackage

// File: hw/rtl/audio_format_rate_list_parser.sv
// ----------------------------------------------------------------------------
// audio_format_rate_list_parser
// Streaming parser for a Type-I audio format descriptor rate list.
// ----------------------------------------------------------------------------
// The block takes one descriptor byte per cycle and reports each sample rate
// as its third byte arrives, then one status item on the marked last byte.
// A byte is parsed in the cycle it is accepted and its results are written
// into a four-entry result queue that drives the output. A byte that finishes
// a rate and also ends the descriptor yields two results, so input is stalled
// whenever fewer than two queue entries are free; with the output draining,
// the sustained rate is one byte per cycle.
module audio_format_rate_list_parser #(
  parameter int MAX_RATES = afrlp_pkg::MaxRatesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_status,
  output logic [23:0] out_rate_value,
  output logic [3:0]  out_rate_index,
  output logic [2:0]  out_status_code,
  output logic [4:0]  out_rate_count,
  output logic        out_last_result,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);
  import afrlp_pkg::*;

  afrlp_push_t push;
  afrlp_item_t item;
  logic        full2;
  logic        take;

  // Input acceptance.
  assign in_stall = full2;
  assign take     = in_valid && !full2;

  afrlp_core #(
    .MAX_RATES (MAX_RATES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push)
  );

  afrlp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full2     (full2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (item)
  );

  // Result fields.
  assign out_is_status   = item.is_status;
  assign out_rate_value  = item.rate_value;
  assign out_rate_index  = item.rate_index;
  assign out_status_code = item.status_code;
  assign out_rate_count  = item.rate_count;
  assign out_last_result = item.last_result;

endmodule

// File: hw/rtl/afrlp_core.sv
// ----------------------------------------------------------------------------
// afrlp_core
// Descriptor state and per-byte parsing; produces up to two results per byte.
// ----------------------------------------------------------------------------
module afrlp_core #(
  parameter int MAX_RATES = afrlp_pkg::MaxRatesDefault
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  logic                  cfg_we,
  input  logic [4:0]            cfg_wdata,
  output afrlp_pkg::afrlp_push_t push
);
  import afrlp_pkg::*;

  localparam logic [7:0] MaxCnt8 = 8'(MAX_RATES);
  localparam logic [4:0] MaxCnt5 = 5'(MAX_RATES);

  logic [4:0] max_r;
  logic [5:0] pos_r, pos_nxt;
  logic       tb_r, tb_nxt;
  logic [7:0] decl_r, decl_nxt;
  logic [15:0] part_r, part_nxt;
  logic [4:0] done_r, done_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [4:0] k_r, k_nxt;

  logic       cnt_ok;
  logic [4:0] clip;
  logic       in_list;
  logic       list_ok;
  logic       emit;
  logic [2:0] code;
  afrlp_item_t rate_item, stat_item;

  // Configuration register; writes outside the legal range are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MaxCnt5;
    end else if (cfg_we && cfg_wdata != 5'd0 && cfg_wdata <= MaxCnt5) begin
      max_r <= cfg_wdata;
    end
  end

  // Parse one byte against the current descriptor state.
  always_comb begin
    tb_nxt = tb_r
           | ((pos_r == PosTypeB) && (data_byte != DescType))
           | ((pos_r == PosSubtypeB) && (data_byte != DescSubtype));
    decl_nxt = (pos_r == PosCountB) ? data_byte : decl_r;
    cnt_ok   = (decl_nxt != 8'd0) && (decl_nxt <= MaxCnt8);
    clip     = (decl_nxt > {3'b000, max_r}) ? max_r : decl_nxt[4:0];
    in_list  = (pos_r >= ListStart);
    list_ok  = in_list && !tb_nxt && cnt_ok && (k_r < clip);
    emit     = list_ok && (ph_r == PhHigh);

    // Rate assembly, little-endian.
    part_nxt = part_r;
    if (list_ok) begin
      unique case (ph_r)
        PhLow:   part_nxt = {8'h00, data_byte};
        PhMid:   part_nxt = {data_byte, part_r[7:0]};
        default: part_nxt = 16'h0000;
      endcase
    end
    done_nxt = done_r + {4'b0000, emit};

    // Phase and list slot advance with the byte position.
    ph_nxt = ph_r;
    k_nxt  = k_r;
    if (in_list && pos_r != PosMax) begin
      if (ph_r == PhHigh) begin
        ph_nxt = PhLow;
        k_nxt  = k_r + 5'd1;
      end else begin
        ph_nxt = ph_r + 2'd1;
      end
    end
    pos_nxt = (pos_r == PosMax) ? pos_r : pos_r + 6'd1;

    // Status by priority.
    priority if (pos_nxt < MinLen) begin
      code = StShort;
    end else if (tb_nxt) begin
      code = StBadType;
    end else if (!cnt_ok) begin
      code = StBadCount;
    end else if (done_nxt < clip) begin
      code = StTruncated;
    end else begin
      code = StOk;
    end

    rate_item             = '0;
    rate_item.rate_value  = {data_byte, part_r};
    rate_item.rate_index  = k_r[3:0];

    stat_item             = '0;
    stat_item.is_status   = 1'b1;
    stat_item.status_code = code;
    stat_item.rate_count  = (code == StOk) ? clip : 5'd0;
    stat_item.last_result = 1'b1;

    // Order the results: a completed rate comes before the status.
    push.num   = {1'b0, emit} + {1'b0, last_byte};
    push.item0 = emit ? rate_item : stat_item;
    push.item1 = stat_item;
    if (!take) begin
      push.num = 2'd0;
    end
  end

  // Descriptor state; the last byte clears it for the next descriptor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      tb_r   <= 1'b0;
      decl_r <= '0;
      part_r <= '0;
      done_r <= '0;
      ph_r   <= PhLow;
      k_r    <= '0;
    end else if (take) begin
      if (last_byte) begin
        pos_r  <= '0;
        tb_r   <= 1'b0;
        decl_r <= '0;
        part_r <= '0;
        done_r <= '0;
        ph_r   <= PhLow;
        k_r    <= '0;
      end else begin
        pos_r  <= pos_nxt;
        tb_r   <= tb_nxt;
        decl_r <= decl_nxt;
        part_r <= part_nxt;
        done_r <= done_nxt;
        ph_r   <= ph_nxt;
        k_r    <= k_nxt;
      end
    end
  end

endmodule

// File: hw/rtl/afrlp_outq.sv
// ----------------------------------------------------------------------------
// afrlp_outq
// Small result queue: takes up to two items per cycle, delivers one unless stalled.
// ----------------------------------------------------------------------------
module afrlp_outq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  afrlp_pkg::afrlp_push_t push,
  output logic                   full2,
  output logic                   out_valid,
  input  logic                   out_stall,
  output afrlp_pkg::afrlp_item_t out_item
);
  import afrlp_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  afrlp_item_t mem_r [QueueDepth];
  logic [PtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [PtrW-1:0] wr_p1;
  logic            pop;

  // Room for two pushes is required before a new byte is taken.
  assign full2     = (cnt_r > CntW'(QueueDepth - 2));
  assign out_valid = (cnt_r != '0);
  assign out_item  = mem_r[rd_r];
  assign pop       = out_valid && !out_stall;
  assign wr_p1     = wr_r + PtrW'(1);

  // Pointer and count update.
  always_comb begin
    wr_nxt  = wr_r + PtrW'(push.num);
    rd_nxt  = rd_r + PtrW'(pop);
    cnt_nxt = cnt_r + CntW'(push.num) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_r] <= push.item0;
    end
    if (push.num == 2'd2) begin
      mem_r[wr_p1] <= push.item1;
    end
  end

endmodule
